>>> rtl/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 7;
  localparam int WORD_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REMOVE     = 3'd4;
  localparam logic [2:0] OP_FIND       = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] popped_value;
    logic                     found;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } deq_out_t;

  // Ring position off places after pos; off stays below DEPTH.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, pos} + {1'b0, off};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/deq_ram.sv
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/double_ended_queue_top.sv
// Pushes, failed pops and unused codes go from IDLE to RESP; a pop that fetches the new
// end word from the ring passes RD_FRONT or RD_BACK first. Requests are taken only in IDLE.
// Find reads (SCAN_RD) and compares (SCAN_CMP) one entry at a time through the single read
// port, up to the match or, on a miss, the last entry. Remove then moves each later entry
// with SHIFT_RD/SHIFT_WR and reloads the ends via REF_F, REF_FB, REF_B (REF_F if empty).
// Reset clears front position, count and handshake state; the ring memory is not cleared.
module double_ended_queue_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_out_t out_data
);
  import deq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_FRONT = 4'd1;
  localparam logic [3:0] S_RD_BACK  = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_SHIFT_RD = 4'd5;
  localparam logic [3:0] S_SHIFT_WR = 4'd6;
  localparam logic [3:0] S_REF_F    = 4'd7;
  localparam logic [3:0] S_REF_FB   = 4'd8;
  localparam logic [3:0] S_REF_B    = 4'd9;
  localparam logic [3:0] S_RESP     = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  front_pos_r, front_pos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [WORD_W-1:0] front_val_r, front_val_nxt;
  logic [WORD_W-1:0] back_val_r, back_val_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic              rm_r, rm_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [WORD_W-1:0] popped_r, popped_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  deq_out_t          out_data_r, out_data_nxt;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic              accept;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [CNT_W-1:0]  k_ext;
  logic [IDX_W-1:0]  k_inc;
  logic              is_full;
  logic              is_empty;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_m2   = count_r - CNT_W'(2);
  assign k_ext    = CNT_W'(k_r);
  assign k_inc    = k_r + IDX_W'(1);
  assign is_full  = (count_r >= CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    front_pos_nxt = front_pos_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    front_val_nxt = front_val_r;
    back_val_nxt  = back_val_r;
    val_nxt       = val_r;
    rm_nxt        = rm_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = front_pos_r;
    mem_wdata     = in_data.value;
    mem_raddr     = front_pos_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_data.operation == OP_POP_FRONT) begin
          mem_raddr = ring_add(front_pos_r, IDX_W'(1));
        end else begin
          mem_raddr = ring_add(front_pos_r, cnt_m2[IDX_W-1:0]);
        end
        if (accept) begin
          status_nxt = ST_OK;
          popped_nxt = '0;
          found_nxt  = 1'b0;
          val_nxt    = in_data.value;
          k_nxt      = '0;
          state_nxt  = S_RESP;
          unique case (in_data.operation)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                front_pos_nxt = (front_pos_r == '0) ? IDX_W'(DEPTH - 1)
                                                    : front_pos_r - IDX_W'(1);
                mem_we        = 1'b1;
                mem_waddr     = front_pos_nxt;
                count_nxt     = count_r + CNT_W'(1);
                front_val_nxt = in_data.value;
                if (is_empty) begin
                  back_val_nxt = in_data.value;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = ring_add(front_pos_r, count_r[IDX_W-1:0]);
                count_nxt    = count_r + CNT_W'(1);
                back_val_nxt = in_data.value;
                if (is_empty) begin
                  front_val_nxt = in_data.value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                popped_nxt    = front_val_r;
                front_pos_nxt = ring_add(front_pos_r, IDX_W'(1));
                count_nxt     = cnt_m1;
                // With three or more entries the new front must come from memory.
                if (count_r > CNT_W'(2)) begin
                  state_nxt = S_RD_FRONT;
                end else begin
                  front_val_nxt = back_val_r;
                end
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                popped_nxt = back_val_r;
                count_nxt  = cnt_m1;
                if (count_r > CNT_W'(2)) begin
                  state_nxt = S_RD_BACK;
                end else begin
                  back_val_nxt = front_val_r;
                end
              end
            end
            OP_REMOVE, OP_FIND: begin
              rm_nxt = (in_data.operation == OP_REMOVE);
              if (is_empty) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_FRONT: begin
        front_val_nxt = mem_rdata;
        state_nxt     = S_RESP;
      end
      S_RD_BACK: begin
        back_val_nxt = mem_rdata;
        state_nxt    = S_RESP;
      end
      S_SCAN_RD: begin
        mem_raddr = ring_add(front_pos_r, k_r);
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (mem_rdata == val_r) begin
          found_nxt = 1'b1;
          if (!rm_r) begin
            state_nxt = S_RESP;
          end else if (k_ext + CNT_W'(1) < count_r) begin
            state_nxt = S_SHIFT_RD;
          end else begin
            count_nxt = cnt_m1;
            state_nxt = S_REF_F;
          end
        end else if (k_ext + CNT_W'(1) >= count_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          k_nxt     = k_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        mem_raddr = ring_add(front_pos_r, k_inc);
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        // Move the entry behind the gap one place toward the front.
        mem_we    = 1'b1;
        mem_waddr = ring_add(front_pos_r, k_r);
        mem_wdata = mem_rdata;
        k_nxt     = k_inc;
        if (k_ext + CNT_W'(2) < count_r) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          count_nxt = cnt_m1;
          state_nxt = S_REF_F;
        end
      end
      S_REF_F: begin
        mem_raddr = front_pos_r;
        state_nxt = is_empty ? S_RESP : S_REF_FB;
      end
      S_REF_FB: begin
        front_val_nxt = mem_rdata;
        mem_raddr     = ring_add(front_pos_r, cnt_m1[IDX_W-1:0]);
        state_nxt     = S_REF_B;
      end
      S_REF_B: begin
        back_val_nxt = mem_rdata;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = status_r;
          out_data_nxt.popped_value = popped_r;
          out_data_nxt.found        = found_r;
          out_data_nxt.count        = count_r;
          out_data_nxt.front_value  = is_empty ? '0 : front_val_r;
          out_data_nxt.back_value   = is_empty ? '0 : back_val_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_pos_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_pos_r <= front_pos_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    front_val_r <= front_val_nxt;
    back_val_r  <= back_val_nxt;
    val_r       <= val_nxt;
    rm_r        <= rm_nxt;
    status_r    <= status_nxt;
    popped_r    <= popped_nxt;
    found_r     <= found_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_SHIFT_WR))
    else $error("ring memory written outside push or shift");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP || state_r == S_SHIFT_RD) |-> (k_ext < count_r))
    else $error("scan position beyond occupied entries");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_full && (in_data.operation == OP_PUSH_FRONT ||
     in_data.operation == OP_PUSH_BACK)) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted push did not grow the queue");

endmodule
